// ===== hw/rtl/lbfl_pkg.sv =====
// Shared types, codes and constants for the linked block free list.
package lbfl_pkg;

  // Link and field widths fixed by the word format
  localparam int LINK_W = 10;
  localparam int FUNC_W = 3;
  localparam int VER_FIELD_W = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_W = 11;

  // Defaults for the top level parameters
  localparam int NUM_BLOCKS_DEF = 1024;
  localparam int NUM_VERSIONS_DEF = 4;

  // Blocks in use after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  // Saturation value of the free count field
  localparam logic [LINK_W-1:0] CNT_MAX = 10'd1023;

  typedef logic [LINK_W-1:0] link_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC  = 3'd0,
    FN_FREE   = 3'd1,
    FN_COUNT  = 3'd2,
    FN_SET    = 3'd3,
    FN_GET    = 3'd4,
    FN_FORMAT = 3'd5
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DUP   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_WALK,
    S_APPEND1,
    S_APPEND2,
    S_COUNT,
    S_SETL,
    S_GET,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/lbfl_req_if.sv =====
// Request channel: operation word into the allocator.
interface lbfl_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [lbfl_pkg::FUNC_W-1:0]           func;
  logic [lbfl_pkg::LINK_W-1:0]           block_id;
  logic [lbfl_pkg::VER_FIELD_W-1:0]      version;
  logic [lbfl_pkg::LINK_W-1:0]           link_value;

  modport source (output valid, func, block_id, version, link_value, input ready);
  modport sink (input valid, func, block_id, version, link_value, output ready);
endinterface

// ===== hw/rtl/lbfl_rsp_if.sv =====
// Response channel: result word out of the allocator.
interface lbfl_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [lbfl_pkg::LINK_W-1:0]     result_block;
  logic [lbfl_pkg::LINK_W-1:0]     free_count;
  logic [lbfl_pkg::STATUS_W-1:0]   status;

  modport source (output valid, result_block, free_count, status, input ready);
  modport sink (input valid, result_block, free_count, status, output ready);
endinterface

// ===== hw/rtl/lbfl_cfg_if.sv =====
// Configuration channel: blocks-in-use register write.
interface lbfl_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lbfl_pkg::CFG_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/lbfl_link_mem.sv =====
// Link table memory: one row per block, one lane per version, lane write mask.
module lbfl_link_mem #(
  parameter int NUM_BLOCKS = lbfl_pkg::NUM_BLOCKS_DEF,
  parameter int NUM_VERSIONS = lbfl_pkg::NUM_VERSIONS_DEF,
  parameter int BLK_W = $clog2(NUM_BLOCKS)
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [BLK_W-1:0]                        wr_addr,
  input  logic [NUM_VERSIONS-1:0]                 wr_mask,
  input  lbfl_pkg::link_t [NUM_VERSIONS-1:0]      wr_row,
  input  logic [BLK_W-1:0]                        rd_addr,
  output lbfl_pkg::link_t [NUM_VERSIONS-1:0]      rd_row
);

  lbfl_pkg::link_t [NUM_VERSIONS-1:0] mem [NUM_BLOCKS];

  // Masked lane write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int l = 0; l < NUM_VERSIONS; l++) begin
        if (wr_mask[l]) begin
          mem[wr_addr][l] <= wr_row[l];
        end
      end
    end
  end

  // Registered row read
  always_ff @(posedge clk) begin
    rd_row <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/linked_block_free_list_core.sv =====
// Top level of the linked block free list allocator.
// Linked block free list: a table of next links per block and version, with the free list
// chained through the version-0 links and a head register. After reset the block runs a
// format sweep (one table row per cycle) before it takes its first word; configuration
// writes are taken meanwhile. One word is worked at a time, through one memory read port
// that is walked one link per cycle. Alloc pops the head block (or reports an empty list),
// free walks the list to its tail and appends the block unless it is rejected or found
// already listed, count walks the whole list, set_link and get_link touch one row, and
// format sweeps every table row. The link memory read latency sets the walk rate and the
// row sweep sets the format time. A finished result sits in the output register while the
// next word is accepted.
module linked_block_free_list_core #(
  parameter int NUM_BLOCKS = lbfl_pkg::NUM_BLOCKS_DEF,
  parameter int NUM_VERSIONS = lbfl_pkg::NUM_VERSIONS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  lbfl_req_if.sink   req,
  lbfl_rsp_if.source rsp,
  lbfl_cfg_if.sink   cfg
);

  localparam int BLK_W = $clog2(NUM_BLOCKS);
  localparam int EFF_W = BLK_W + 1;
  localparam int VER_W = (NUM_VERSIONS > 1) ? $clog2(NUM_VERSIONS) : 1;
  localparam logic [31:0] NB32 = 32'(NUM_BLOCKS);
  localparam logic [31:0] NV32 = 32'(NUM_VERSIONS);
  localparam int RST_N = (NUM_BLOCKS < 1024) ? NUM_BLOCKS : 1024;
  localparam logic [BLK_W-1:0] LAST = BLK_W'(NUM_BLOCKS - 1);
  localparam int LW = lbfl_pkg::LINK_W;

  lbfl_pkg::state_t state, state_next;

  // Configuration and list state
  logic [lbfl_pkg::CFG_W-1:0] blocks_in_use;
  lbfl_pkg::link_t head;

  // Walk pointer and latched request
  lbfl_pkg::link_t cur, cur_next;
  logic cur_ok;
  lbfl_pkg::link_t id_r, lv_r;
  logic [lbfl_pkg::VER_FIELD_W-1:0] ver_r;
  logic [BLK_W-1:0] steps;

  // Format sweep
  logic [BLK_W-1:0] idx;
  logic [EFF_W-1:0] fmt_n;
  logic fmt_reply;

  // Pending result and output register
  lbfl_pkg::link_t r_block, r_cnt;
  lbfl_pkg::status_t r_st;
  logic out_valid;
  lbfl_pkg::link_t out_block, out_cnt;
  lbfl_pkg::status_t out_st;

  // Memory ports
  logic wr_en;
  logic [BLK_W-1:0] wr_addr;
  logic [NUM_VERSIONS-1:0] wr_mask;
  lbfl_pkg::link_t [NUM_VERSIONS-1:0] wr_row;
  lbfl_pkg::link_t [NUM_VERSIONS-1:0] rd_row;

  // Decoded helpers
  logic acc;
  lbfl_pkg::func_t req_func;
  logic [31:0] cfg32, eff32, id32, idx32;
  logic [EFF_W-1:0] eff;
  logic free_ok, ver_ok, id_ok;
  lbfl_pkg::link_t link0, chain_link, get_val, cnt_val;
  logic [31:0] cnt32;

  lbfl_link_mem #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .NUM_VERSIONS(NUM_VERSIONS),
    .BLK_W(BLK_W)
  ) u_mem (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_mask(wr_mask),
    .wr_row(wr_row),
    .rd_addr(BLK_W'(cur_next)),
    .rd_row(rd_row)
  );

  assign req.ready = (state == lbfl_pkg::S_IDLE);
  assign acc = req.valid && req.ready;
  assign req_func = lbfl_pkg::func_t'(req.func);
  assign cfg.ready = 1'b1;

  assign rsp.valid = out_valid;
  assign rsp.result_block = out_block;
  assign rsp.free_count = out_cnt;
  assign rsp.status = out_st;

  // Effective blocks in use, clamped to [2, NUM_BLOCKS]
  assign cfg32 = 32'(blocks_in_use);
  assign eff32 = (cfg32 < 32'd2) ? 32'd2 : ((cfg32 > NB32) ? NB32 : cfg32);
  assign eff = EFF_W'(eff32);
  assign free_ok = (req.block_id != '0) && (32'(req.block_id) < eff32);

  // Range checks on the latched request
  assign id32 = 32'(id_r);
  assign id_ok = id32 < NB32;
  assign ver_ok = 32'(ver_r) < NV32;

  // Link of the row at the walk pointer, zero when out of table range
  assign link0 = cur_ok ? rd_row[0] : '0;
  assign get_val = (cur_ok && ver_ok) ? rd_row[VER_W'(ver_r)] : '0;

  // Format chain value of the swept row
  assign idx32 = 32'(idx);
  assign chain_link = ((idx32 != 32'd0) && (idx32 + 32'd1 < 32'(fmt_n))) ?
                      LW'(idx32 + 32'd1) : '0;

  // Count of entries walked, saturated to the field
  assign cnt32 = 32'(steps) + 32'd1;
  assign cnt_val = (cnt32 > 32'(lbfl_pkg::CNT_MAX)) ? lbfl_pkg::CNT_MAX : LW'(cnt32);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbfl_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, walk pointer and memory writes
  always_comb begin
    state_next = state;
    cur_next = cur;
    wr_en = 1'b0;
    wr_addr = BLK_W'(cur);
    wr_mask = '0;
    wr_row = '0;
    case (state)
      lbfl_pkg::S_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = idx;
        wr_mask = '1;
        wr_row[0] = chain_link;
        if (idx == LAST) begin
          state_next = fmt_reply ? lbfl_pkg::S_DONE : lbfl_pkg::S_IDLE;
        end
      end
      lbfl_pkg::S_IDLE: begin
        if (acc) begin
          case (req_func)
            lbfl_pkg::FN_ALLOC: begin
              cur_next = head;
              state_next = (head == '0) ? lbfl_pkg::S_DONE : lbfl_pkg::S_ALLOC;
            end
            lbfl_pkg::FN_FREE: begin
              cur_next = head;
              if (!free_ok) begin
                state_next = lbfl_pkg::S_DONE;
              end else if (head == '0) begin
                state_next = lbfl_pkg::S_APPEND2;
              end else begin
                state_next = lbfl_pkg::S_WALK;
              end
            end
            lbfl_pkg::FN_COUNT: begin
              cur_next = head;
              state_next = (head == '0) ? lbfl_pkg::S_DONE : lbfl_pkg::S_COUNT;
            end
            lbfl_pkg::FN_SET:    state_next = lbfl_pkg::S_SETL;
            lbfl_pkg::FN_GET: begin
              cur_next = req.block_id;
              state_next = lbfl_pkg::S_GET;
            end
            lbfl_pkg::FN_FORMAT: state_next = lbfl_pkg::S_CLEAR;
            default:             state_next = lbfl_pkg::S_DONE;
          endcase
        end
      end
      lbfl_pkg::S_ALLOC: state_next = lbfl_pkg::S_DONE;
      lbfl_pkg::S_WALK: begin
        if (cur == id_r) begin
          state_next = lbfl_pkg::S_DONE;
        end else if (link0 == '0) begin
          state_next = lbfl_pkg::S_APPEND1;
        end else if (steps == LAST) begin
          state_next = lbfl_pkg::S_DONE;
        end else begin
          cur_next = link0;
        end
      end
      lbfl_pkg::S_APPEND1: begin
        // tail now points at the freed block
        wr_en = cur_ok;
        wr_addr = BLK_W'(cur);
        wr_mask[0] = 1'b1;
        wr_row[0] = id_r;
        state_next = lbfl_pkg::S_APPEND2;
      end
      lbfl_pkg::S_APPEND2: begin
        // freed block ends the list
        wr_en = 1'b1;
        wr_addr = BLK_W'(id_r);
        wr_mask[0] = 1'b1;
        state_next = lbfl_pkg::S_DONE;
      end
      lbfl_pkg::S_COUNT: begin
        if ((link0 == '0) || (steps == LAST)) begin
          state_next = lbfl_pkg::S_DONE;
        end else begin
          cur_next = link0;
        end
      end
      lbfl_pkg::S_SETL: begin
        wr_en = id_ok && ver_ok;
        wr_addr = BLK_W'(id_r);
        wr_mask = NUM_VERSIONS'(1) << ver_r;
        for (int l = 0; l < NUM_VERSIONS; l++) begin
          wr_row[l] = lv_r;
        end
        state_next = lbfl_pkg::S_DONE;
      end
      lbfl_pkg::S_GET: state_next = lbfl_pkg::S_DONE;
      lbfl_pkg::S_DONE: begin
        if (!out_valid || rsp.ready) begin
          state_next = lbfl_pkg::S_IDLE;
        end
      end
      default: state_next = lbfl_pkg::S_IDLE;
    endcase
  end

  // Datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= lbfl_pkg::CFG_RESET;
      head <= LW'(1);
      idx <= '0;
      fmt_n <= EFF_W'(RST_N);
      fmt_reply <= 1'b0;
      out_valid <= 1'b0;
      cur <= '0;
      cur_ok <= 1'b0;
      steps <= '0;
    end else begin
      cur <= cur_next;
      cur_ok <= 32'(cur_next) < NB32;

      if (cfg.valid && cfg.ready) begin
        blocks_in_use <= cfg.data;
      end

      // Output valid: set when a finished word loads, cleared once taken
      if ((state == lbfl_pkg::S_DONE) && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        lbfl_pkg::S_CLEAR: idx <= idx + BLK_W'(1);
        lbfl_pkg::S_IDLE: begin
          if (acc) begin
            id_r <= req.block_id;
            ver_r <= req.version;
            lv_r <= req.link_value;
            r_block <= '0;
            r_cnt <= '0;
            r_st <= lbfl_pkg::ST_OK;
            steps <= '0;
            case (req_func)
              lbfl_pkg::FN_ALLOC: begin
                if (head == '0) begin
                  r_st <= lbfl_pkg::ST_EMPTY;
                end
              end
              lbfl_pkg::FN_FREE: begin
                if (free_ok && (head == '0)) begin
                  head <= req.block_id;
                end
              end
              lbfl_pkg::FN_FORMAT: begin
                idx <= '0;
                fmt_n <= eff;
                fmt_reply <= 1'b1;
                head <= LW'(1);
              end
              default: ;
            endcase
          end
        end
        lbfl_pkg::S_ALLOC: begin
          r_block <= cur;
          head <= link0;
        end
        lbfl_pkg::S_WALK: begin
          if (cur == id_r) begin
            r_st <= lbfl_pkg::ST_DUP;
          end
          steps <= steps + BLK_W'(1);
        end
        lbfl_pkg::S_COUNT: begin
          r_cnt <= cnt_val;
          steps <= steps + BLK_W'(1);
        end
        lbfl_pkg::S_GET: r_block <= get_val;
        lbfl_pkg::S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_block <= r_block;
            out_cnt <= r_cnt;
            out_st <= r_st;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
